[rtl/core/framed_stream_deframer_macros.svh]
// Assertion helpers shared by the deframer RTL.
// Both macros sample on the block clock and are switched off while reset is held.
`ifndef FRAMED_STREAM_DEFRAMER_MACROS_SVH
`define FRAMED_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define FSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framed_stream_deframer: same-cycle check failed");

// Implication checked in the next cycle.
`define FSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framed_stream_deframer: next-cycle check failed");

`endif

[rtl/core/fsd_pkg.sv]
package fsd_pkg;

    localparam int MAX_MARKER_BYTES = 4;
    localparam int MARKER_LIMIT_INT = (MAX_MARKER_BYTES < 4) ? MAX_MARKER_BYTES : 4;
    localparam logic [2:0] MARKER_LIMIT = 3'(MARKER_LIMIT_INT);
    localparam logic [2:0] LEN_FIELD_MAX = 3'd4;
    localparam logic [2:0] WINDOW_BYTES = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [31:0] RST_START_PATTERN = 32'd11;
    localparam logic [2:0] RST_START_LENGTH = 3'd1;
    localparam logic [31:0] RST_END_PATTERN = 32'd28;
    localparam logic [2:0] RST_END_LENGTH = 3'd1;
    localparam logic [31:0] RST_TRAILER_PATTERN = 32'd13;
    localparam logic [2:0] RST_TRAILER_LENGTH = 3'd1;
    localparam logic [2:0] RST_LEN_FIELD_BYTES = 3'd0;
    localparam logic [31:0] RST_MAX_PAYLOAD = 32'd65535;

    // Result queue between the front and the back.
    localparam int QUEUE_AW = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_PATTERN   = 3'd0,
        CFG_START_LENGTH    = 3'd1,
        CFG_END_PATTERN     = 3'd2,
        CFG_END_LENGTH      = 3'd3,
        CFG_TRAILER_PATTERN = 3'd4,
        CFG_TRAILER_LENGTH  = 3'd5,
        CFG_LEN_FIELD_BYTES = 3'd6,
        CFG_MAX_PAYLOAD     = 3'd7
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_END     = 3'd3,
        PH_TRAILER = 3'd4,
        PH_SEARCH  = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       frame_good;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_res_req;

endpackage

[rtl/core/fsd_front.sv]
module fsd_front import fsd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [7:0]             i_in_byte,
    output logic                   o_in_stall,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_q_full,
    output t_res_req               o_push,
    output t_phase                 o_phase
);

    // Clamp a marker length into [lo, MARKER_LIMIT].
    function automatic logic [2:0] eff_len(input logic [2:0] v, input logic [2:0] lo);
        logic [2:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > MARKER_LIMIT) begin
            r = MARKER_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Newest n bytes of the window (oldest lowest) against the low n bytes of pat.
    function automatic logic window_match(input logic [31:0] win, input logic [31:0] pat,
                                          input logic [2:0] n);
        logic m;
        case (n)
            3'd2:    m = (win[31:16] == pat[15:0]);
            3'd3:    m = (win[31:8] == pat[23:0]);
            3'd4:    m = (win == pat);
            default: m = (win[31:24] == pat[7:0]);
        endcase
        return m;
    endfunction

    logic [31:0] r_start_pattern, r_end_pattern, r_trailer_pattern, r_max_payload;
    logic [2:0]  r_start_length, r_end_length, r_trailer_length, r_len_field_bytes;

    t_phase      r_phase, n_phase;
    logic [31:0] r_recent, n_recent;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_fcnt, n_fcnt;
    logic [31:0] r_rem, n_rem;
    logic [2:0]  r_mcnt, n_mcnt;
    logic [2:0]  r_held, n_held;

    logic [2:0]  slen, elen, tlen, lfb;
    logic        accept, go_hunt, is_end, held_emit;
    logic [31:0] acc_upd, rem_dec, shifted, mark_pat;
    logic [2:0]  fcnt_inc, mcnt_inc, held_sat, held_new, hunt_held, mark_len;
    logic [1:0]  emit_idx;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pattern   <= RST_START_PATTERN;
            r_start_length    <= RST_START_LENGTH;
            r_end_pattern     <= RST_END_PATTERN;
            r_end_length      <= RST_END_LENGTH;
            r_trailer_pattern <= RST_TRAILER_PATTERN;
            r_trailer_length  <= RST_TRAILER_LENGTH;
            r_len_field_bytes <= RST_LEN_FIELD_BYTES;
            r_max_payload     <= RST_MAX_PAYLOAD;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_START_PATTERN:   r_start_pattern   <= i_cfg_data;
                CFG_START_LENGTH:    r_start_length    <= i_cfg_data[2:0];
                CFG_END_PATTERN:     r_end_pattern     <= i_cfg_data;
                CFG_END_LENGTH:      r_end_length      <= i_cfg_data[2:0];
                CFG_TRAILER_PATTERN: r_trailer_pattern <= i_cfg_data;
                CFG_TRAILER_LENGTH:  r_trailer_length  <= i_cfg_data[2:0];
                CFG_LEN_FIELD_BYTES: r_len_field_bytes <= i_cfg_data[2:0];
                CFG_MAX_PAYLOAD:     r_max_payload     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign slen = eff_len(r_start_length, 3'd1);
    assign elen = eff_len(r_end_length, 3'd1);
    assign tlen = eff_len(r_trailer_length, 3'd0);
    assign lfb  = (r_len_field_bytes > LEN_FIELD_MAX) ? LEN_FIELD_MAX : r_len_field_bytes;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        n_phase   = r_phase;
        n_recent  = r_recent;
        n_acc     = r_acc;
        n_fcnt    = r_fcnt;
        n_rem     = r_rem;
        n_mcnt    = r_mcnt;
        n_held    = r_held;
        res       = '0;
        go_hunt   = 1'b0;

        acc_upd   = r_acc | ({24'd0, i_in_byte} << {r_fcnt[1:0], 3'b000});
        fcnt_inc  = r_fcnt + 3'd1;
        rem_dec   = r_rem - 32'd1;
        mcnt_inc  = r_mcnt + 3'd1;
        shifted   = {i_in_byte, r_recent[31:8]};
        held_sat  = (r_held > WINDOW_BYTES) ? WINDOW_BYTES : r_held;
        held_emit = (held_sat >= elen) && (held_sat != 3'd0);
        held_new  = held_emit ? held_sat : held_sat + 3'd1;
        emit_idx  = 2'(WINDOW_BYTES - held_sat);
        hunt_held = (r_held < WINDOW_BYTES) ? r_held + 3'd1 : r_held;
        is_end    = (r_phase == PH_END);
        mark_pat  = is_end ? r_end_pattern : r_trailer_pattern;
        mark_len  = is_end ? elen : tlen;

        case (r_phase)
            PH_LENGTH: begin
                n_acc  = acc_upd;
                n_fcnt = fcnt_inc;
                if (fcnt_inc >= lfb) begin
                    if (acc_upd == 32'd0 || acc_upd > r_max_payload) begin
                        res.frame_end = 1'b1;
                        go_hunt       = 1'b1;
                    end else begin
                        n_rem   = acc_upd;
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                res.out_byte   = i_in_byte;
                res.byte_valid = 1'b1;
                n_rem          = rem_dec;
                if (rem_dec == 32'd0) begin
                    n_phase = PH_END;
                    n_mcnt  = 3'd0;
                end
            end
            PH_END, PH_TRAILER: begin
                if (i_in_byte != mark_pat[{r_mcnt[1:0], 3'b000} +: 8]) begin
                    res.frame_end = 1'b1;
                    go_hunt       = 1'b1;
                end else begin
                    n_mcnt = mcnt_inc;
                    if (mcnt_inc >= mark_len) begin
                        if (is_end && tlen != 3'd0) begin
                            n_phase = PH_TRAILER;
                            n_mcnt  = 3'd0;
                        end else begin
                            res.frame_end  = 1'b1;
                            res.frame_good = 1'b1;
                            go_hunt        = 1'b1;
                        end
                    end
                end
            end
            PH_SEARCH: begin
                if (held_emit) begin
                    res.out_byte   = r_recent[{emit_idx, 3'b000} +: 8];
                    res.byte_valid = 1'b1;
                end
                n_recent = shifted;
                n_held   = held_new;
                if (held_new >= elen && window_match(shifted, r_end_pattern, elen)) begin
                    if (tlen != 3'd0) begin
                        n_phase  = PH_TRAILER;
                        n_mcnt   = 3'd0;
                        n_held   = 3'd0;
                        n_recent = 32'd0;
                    end else begin
                        res.frame_end  = 1'b1;
                        res.frame_good = 1'b1;
                        go_hunt        = 1'b1;
                    end
                end
            end
            default: begin
                n_recent = shifted;
                n_held   = hunt_held;
                if (hunt_held >= slen && window_match(shifted, r_start_pattern, slen)) begin
                    n_recent = 32'd0;
                    n_held   = 3'd0;
                    n_acc    = 32'd0;
                    n_fcnt   = 3'd0;
                    n_mcnt   = 3'd0;
                    n_phase  = (lfb != 3'd0) ? PH_LENGTH : PH_SEARCH;
                end
            end
        endcase

        if (go_hunt) begin
            n_phase  = PH_HUNT;
            n_recent = 32'd0;
            n_held   = 3'd0;
            n_acc    = 32'd0;
            n_fcnt   = 3'd0;
            n_rem    = 32'd0;
            n_mcnt   = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_recent <= 32'd0;
            r_acc    <= 32'd0;
            r_fcnt   <= 3'd0;
            r_rem    <= 32'd0;
            r_mcnt   <= 3'd0;
            r_held   <= 3'd0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_acc    <= n_acc;
            r_fcnt   <= n_fcnt;
            r_rem    <= n_rem;
            r_mcnt   <= n_mcnt;
            r_held   <= n_held;
        end
    end

    assign o_push.valid = accept && (res.byte_valid || res.frame_end);
    assign o_push.res   = res;
    assign o_phase      = r_phase;

endmodule

[rtl/core/fsd_queue.sv]
module fsd_queue import fsd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_res_req i_push,
    input  logic     i_pop,
    output logic     o_full,
    output t_res_req o_head
);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.res;
        end
    end

    assign o_full       = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.res   = r_mem[r_rd];

endmodule

[rtl/core/fsd_back.sv]
module fsd_back import fsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_res_req   i_head,
    output logic       o_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_frame_end,
    output logic       o_frame_good
);

    logic    r_valid;
    t_result r_res;

    // Refill the output register whenever it is empty or being taken.
    assign o_pop = i_head.valid && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head.res;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_res.out_byte;
    assign o_byte_valid = r_res.byte_valid;
    assign o_frame_end  = r_res.frame_end;
    assign o_frame_good = r_res.frame_good;

endmodule

[rtl/core/framed_stream_deframer.sv]
// Throughput: one byte per clock while the queue is not full; the frame parser finishes
// each byte in the cycle it is accepted. A result enters the queue with its byte, then
// the output register. Bytes that produce no result (markers, length field, hunting) leave
// nothing behind. Reset (synchronous, active low): parser hunts for the start pattern,
// queue and output register empty, configuration registers back to their defaults.
`include "framed_stream_deframer_macros.svh"

module framed_stream_deframer import fsd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Byte input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_in_byte,
    // Result output channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_out_byte,
    output logic                   o_byte_valid,
    output logic                   o_frame_end,
    output logic                   o_frame_good,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // The front end owns the configuration and the frame parser. Every accepted
    // byte is classified in the cycle it arrives, and any request it produces
    // (a payload byte, a frame end marker, or both) is pushed into a short queue.
    // The input is stalled only while that queue is full, so the parser keeps
    // running while the downstream side holds a finished request.
    t_res_req push;
    t_res_req q_head;
    logic     q_full;
    logic     q_pop;
    t_phase   front_phase;

    fsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_byte   (i_in_byte),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_phase     (front_phase)
    );

    // The queue decouples the parser from the output handshake.
    fsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    // The back end is the output register; it reloads from the queue whenever
    // it is empty or its request is taken, so an unstalled stream moves one per clock.
    fsd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_frame_end  (o_frame_end),
        .o_frame_good (o_frame_good)
    );

    // A request is only produced when the queue has room for it.
    `FSD_ASSERT_NOW(a_push_has_room, push.valid, !q_full)
    // The back end never pops an empty queue.
    `FSD_ASSERT_NOW(a_pop_has_data, q_pop, q_head.valid)
    // Every delivered request carries a payload byte or a frame end.
    `FSD_ASSERT_NOW(a_result_not_empty, o_out_valid, o_byte_valid || o_frame_end)
    // Closing a frame always sends the parser back to hunting.
    `FSD_ASSERT_NEXT(a_end_rehunts, push.valid && push.res.frame_end, front_phase == PH_HUNT)

endmodule
